[rtl/ihexw_pkg.sv]
// Shared types, codes and helpers of the Intel HEX record writer.
package ihexw_pkg;

	// Default record length and command queue depth
	localparam int RECORD_BYTES_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 2;

	// Input command codes as they arrive in tuser
	localparam logic [1:0] CMD_DATA   = 2'd0;
	localparam logic [1:0] CMD_ADDR   = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Operation kinds carried through the queue
	localparam logic [1:0] OP_DATA   = 2'd0;
	localparam logic [1:0] OP_ADDR   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// ASCII characters
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_A       = 8'h41;

	// One queued operation
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] addr;
	} op_t;

	localparam int OP_W = $bits(op_t);

	// Upper-case hex digit for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CHAR_ZERO + {4'd0, nib};
		end else begin
			c = CHAR_A + {4'd0, nib} - 8'd10;
		end
		return c;
	endfunction

endpackage

[rtl/ihexw_front.sv]
// Front end: accepts input transfers, decodes the command and queues an operation.
module ihexw_front (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        s_tuser,   // command[1:0]
	input  logic [23:0]       s_tdata,   // data_byte[7:0], load_address[23:8]
	input  logic              q_full,
	output logic              q_push,
	output ihexw_pkg::op_t    q_op
);
	import ihexw_pkg::*;

	logic cmd_valid;

	// Unused command code is taken and dropped
	always_comb begin
		unique case (s_tuser)
			CMD_DATA:   cmd_valid = 1'b1;
			CMD_ADDR:   cmd_valid = 1'b1;
			CMD_FINISH: cmd_valid = 1'b1;
			default:    cmd_valid = 1'b0;
		endcase
	end

	// Map command to operation kind
	always_comb begin
		q_op.data = s_tdata[7:0];
		q_op.addr = s_tdata[23:8];
		unique case (s_tuser)
			CMD_ADDR:   q_op.kind = OP_ADDR;
			CMD_FINISH: q_op.kind = OP_FINISH;
			default:    q_op.kind = OP_DATA;
		endcase
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && cmd_valid;

endmodule

[rtl/ihexw_queue.sv]
// Small FIFO between front end and record emitter.
module ihexw_queue #(
	parameter int WIDTH = ihexw_pkg::OP_W,
	parameter int DEPTH = ihexw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	import ihexw_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/ihexw_back.sv]
// Back end: record buffer, address tracking and character sequencer.
module ihexw_back #(
	parameter int RECORD_BYTES = ihexw_pkg::RECORD_BYTES_DEF,
	parameter int CW           = $clog2(RECORD_BYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  ihexw_pkg::op_t    op,
	output logic              op_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // ascii_char[7:0]
	output logic              m_tlast,
	output logic              busy,
	output logic [CW-1:0]     level
);
	import ihexw_pkg::*;

	localparam int IW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam int KW = $clog2(RECORD_BYTES + 5);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_COLON = 2'd1;
	localparam logic [1:0] ST_BYTE  = 2'd2;
	localparam logic [1:0] ST_NL    = 2'd3;

	logic [1:0]    state_q;
	logic [7:0]    rec_mem_q [RECORD_BYTES];
	logic [CW-1:0] byte_count_q;
	logic [15:0]   record_address_q;
	logic [15:0]   new_addr_q;
	logic          load_q;       // load new_addr_q once the flush record ends
	logic          end_q;        // record in progress is the end record
	logic          pend_end_q;   // end record follows the flush record
	logic [KW-1:0] k_q;          // byte index within the record
	logic          nib_q;        // 0 high digit, 1 low digit
	logic [7:0]    sum_q;
	logic          m_tvalid_q;
	logic [7:0]    m_tdata_q;
	logic          m_tlast_q;

	logic          take;
	logic          emit;
	logic [CW-1:0] rec_cnt;
	logic [KW-1:0] chk_k;
	logic [KW-1:0] data_off;
	logic [7:0]    cur_byte;
	logic [7:0]    cur_char;
	logic          cur_last;
	logic [CW-1:0] count_inc;

	assign op_pop    = (state_q == ST_IDLE);
	assign take      = op_valid && (state_q == ST_IDLE);
	assign emit      = (state_q != ST_IDLE) && (!m_tvalid_q || m_tready);
	assign count_inc = byte_count_q + 1'b1;

	// Field selection for the current record byte
	assign rec_cnt  = end_q ? '0 : byte_count_q;
	assign chk_k    = KW'(rec_cnt) + KW'(4);
	assign data_off = k_q - KW'(4);

	always_comb begin
		if (k_q == KW'(0)) begin
			cur_byte = 8'(rec_cnt);
		end else if (k_q == KW'(1)) begin
			cur_byte = end_q ? 8'h00 : record_address_q[15:8];
		end else if (k_q == KW'(2)) begin
			cur_byte = end_q ? 8'h00 : record_address_q[7:0];
		end else if (k_q == KW'(3)) begin
			cur_byte = end_q ? 8'h01 : 8'h00;
		end else if (k_q == chk_k) begin
			cur_byte = 8'h00 - sum_q;
		end else begin
			cur_byte = rec_mem_q[data_off[IW-1:0]];
		end
	end

	// Character for the current sequencer step
	always_comb begin
		cur_last = 1'b0;
		unique case (state_q)
			ST_COLON: cur_char = CHAR_COLON;
			ST_BYTE:  cur_char = hex_char(nib_q ? cur_byte[3:0] : cur_byte[7:4]);
			ST_NL: begin
				cur_char = CHAR_NEWLINE;
				cur_last = end_q || !pend_end_q;
			end
			default:  cur_char = CHAR_NEWLINE;
		endcase
	end

	// Record buffer write
	always_ff @(posedge clk) begin
		if (take && (op.kind == OP_DATA)) begin
			rec_mem_q[byte_count_q[IW-1:0]] <= op.data;
		end
	end

	// Sequencer and record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			byte_count_q     <= '0;
			record_address_q <= '0;
			new_addr_q       <= '0;
			load_q           <= 1'b0;
			end_q            <= 1'b0;
			pend_end_q       <= 1'b0;
			k_q              <= '0;
			nib_q            <= 1'b0;
			sum_q            <= '0;
		end else if (take) begin
			unique case (op.kind)
				OP_DATA: begin
					byte_count_q <= count_inc;
					if (count_inc == CW'(RECORD_BYTES)) begin
						state_q <= ST_COLON;
					end
				end
				OP_ADDR: begin
					if (byte_count_q != '0) begin
						state_q    <= ST_COLON;
						load_q     <= 1'b1;
						new_addr_q <= op.addr;
					end else begin
						record_address_q <= op.addr;
					end
				end
				OP_FINISH: begin
					state_q <= ST_COLON;
					if (byte_count_q != '0) begin
						pend_end_q <= 1'b1;
					end else begin
						end_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end else if (emit) begin
			unique case (state_q)
				ST_COLON: begin
					state_q <= ST_BYTE;
					k_q     <= '0;
					nib_q   <= 1'b0;
					sum_q   <= '0;
				end
				ST_BYTE: begin
					nib_q <= !nib_q;
					if (nib_q) begin
						sum_q <= sum_q + cur_byte;
						if (k_q == chk_k) begin
							state_q <= ST_NL;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_NL: begin
					if (end_q) begin
						end_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						// data record done: advance or reload the address
						record_address_q <= load_q ? new_addr_q
							: record_address_q + 16'(byte_count_q);
						load_q       <= 1'b0;
						byte_count_q <= '0;
						if (pend_end_q) begin
							pend_end_q <= 1'b0;
							end_q      <= 1'b1;
							state_q    <= ST_COLON;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= cur_char;
			m_tlast_q <= cur_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign busy     = (state_q != ST_IDLE);
	assign level    = byte_count_q;

endmodule

[rtl/intel_hex_record_writer_top.sv]
// Top level of the Intel HEX record writer: front end, command queue, record emitter.
//
// Channel   Dir  Handshake            tdata                         tuser / tlast
// s_*       in   s_tvalid/s_tready    data_byte, load_address       tuser = command
// m_*       out  m_tvalid/m_tready    ascii_char                    tlast = last_char
//
// A data byte that does not fill the buffer is only stored; the emitter stays idle and
// can take the next command. A record is sent one character per cycle by the single
// sequencer, as long as the output register is not held.
// Input is taken while the command queue has room, so the front keeps accepting
// while a record is sent; the emitter stalls when the output register is held.
// Asynchronous active-low reset empties the queue and clears count and address.
module intel_hex_record_writer_top #(
	parameter int RECORD_BYTES = ihexw_pkg::RECORD_BYTES_DEF,
	parameter int QUEUE_DEPTH  = ihexw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // command[1:0]
	input  logic [23:0] s_tdata,   // data_byte[7:0], load_address[23:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // ascii_char[7:0]
	output logic        m_tlast
);
	import ihexw_pkg::*;

	localparam int CW = $clog2(RECORD_BYTES + 1);

	logic          q_push;
	logic          q_full;
	op_t           q_in;
	op_t           q_out;
	logic          q_not_empty;
	logic          q_pop;
	logic          busy;
	logic [CW-1:0] level;

	ihexw_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (q_in)
	);

	ihexw_queue #(
		.WIDTH (OP_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_out)
	);

	ihexw_back #(
		.RECORD_BYTES (RECORD_BYTES),
		.CW           (CW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_not_empty),
		.op       (q_out),
		.op_pop   (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.busy     (busy),
		.level    (level)
	);

	// Buffer level never passes the record length
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= CW'(RECORD_BYTES))
		else $error("record buffer level out of range");

	// The final character of a command is always the newline
	a_last_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata == CHAR_NEWLINE))
		else $error("last character is not a newline");

	// Queue is never pushed while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

	// Emitter only starts work from a queued operation
	a_busy_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(q_not_empty))
		else $error("emitter started without a queued operation");

endmodule
